// File: rtl/hrht_pkg.sv
// Shared types and character constants for the HTTP request header tokenizer.
package hrht_pkg;

    localparam int ByteW = 8;
    localparam int KindW = 3;

    typedef logic [ByteW-1:0] t_byte;

    typedef enum logic [KindW-1:0] {
        K_NONE    = 3'd0,
        K_METHOD  = 3'd1,
        K_PATH    = 3'd2,
        K_QUERY   = 3'd3,
        K_VERSION = 3'd4,
        K_NAME    = 3'd5,
        K_VALUE   = 3'd6
    } t_kind;

    localparam t_byte ChSp    = 8'h20;
    localparam t_byte ChQuest = 8'h3F;
    localparam t_byte ChUpH   = 8'h48;
    localparam t_byte ChCr    = 8'h0D;
    localparam t_byte ChLf    = 8'h0A;
    localparam t_byte ChColon = 8'h3A;
    localparam t_byte ChHt    = 8'h09;

    localparam int CookieLen = 6;
    localparam int MatchW    = 3;

    typedef struct packed {
        t_byte out_byte;
        t_kind kind;
        t_kind closes;
        logic  name_is_cookie;
        logic  headers_done;
        logic  parse_error;
    } t_result;

    // Characters of the header name "cookie", one per match position.
    function automatic t_byte cookie_char(input logic [MatchW-1:0] idx);
        t_byte c;
        case (idx)
            3'd0:    c = 8'h63;
            3'd1:    c = 8'h6F;
            3'd2:    c = 8'h6F;
            3'd3:    c = 8'h6B;
            3'd4:    c = 8'h69;
            3'd5:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_ws(input t_byte b);
        return (b == ChSp) || (b inside {[ChHt:ChCr]});
    endfunction

endpackage

// File: rtl/hrht_if.sv
// Valid/ready stream interfaces for the tokenizer's input and result channels.
interface hrht_in_if;
    logic               valid;
    logic               ready;
    hrht_pkg::t_byte    in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface hrht_out_if;
    logic               valid;
    logic               ready;
    hrht_pkg::t_byte    out_byte;
    hrht_pkg::t_kind    kind;
    hrht_pkg::t_kind    closes;
    logic               name_is_cookie;
    logic               headers_done;
    logic               parse_error;

    modport source (output valid, output out_byte, output kind, output closes,
                    output name_is_cookie, output headers_done, output parse_error,
                    input ready);
    modport sink   (input valid, input out_byte, input kind, input closes,
                    input name_is_cookie, input headers_done, input parse_error,
                    output ready);
endinterface

// File: rtl/hrht_parser.sv
// Parse-position state machine: classifies one byte and advances on each step.
module hrht_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  hrht_pkg::t_byte     i_byte,
    output hrht_pkg::t_result   o_result
);
    import hrht_pkg::*;

    typedef enum logic [3:0] {
        ST_METHOD_BEFORE,
        ST_METHOD,
        ST_PATH_BEFORE,
        ST_PATH,
        ST_QUERY,
        ST_VERSION_BEFORE,
        ST_VERSION,
        ST_VERSION_LF,
        ST_NAME,
        ST_VALUE_BEFORE,
        ST_VALUE,
        ST_VALUE_LF,
        ST_BLANK_LF,
        ST_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [MatchW-1:0]   r_match, n_match;
    logic                r_miss, n_miss;
    logic                r_err, n_err;
    logic                bad;
    t_result             res;

    always_comb begin
        n_state            = r_state;
        n_match            = r_match;
        n_miss             = r_miss;
        bad                = 1'b0;
        res.out_byte       = i_byte;
        res.kind           = K_NONE;
        res.closes         = K_NONE;
        res.name_is_cookie = 1'b0;
        res.headers_done   = 1'b0;
        if (!r_err) begin
            case (r_state)
                ST_METHOD_BEFORE, ST_METHOD: begin
                    if (r_state == ST_METHOD_BEFORE && i_byte == ChSp) begin
                        bad = 1'b1;
                    end else if (r_state == ST_METHOD && is_ws(i_byte)) begin
                        res.closes = K_METHOD;
                        n_state    = ST_PATH_BEFORE;
                    end else begin
                        if (i_byte inside {[8'h61:8'h7A]}) begin
                            res.out_byte = i_byte - 8'd32;
                        end
                        res.kind = K_METHOD;
                        n_state  = ST_METHOD;
                    end
                end
                ST_PATH_BEFORE: begin
                    if (i_byte == ChSp) begin
                        bad = 1'b1;
                    end else begin
                        res.kind = K_PATH;
                        n_state  = ST_PATH;
                    end
                end
                ST_PATH: begin
                    if (i_byte == ChQuest) begin
                        res.closes = K_PATH;
                        n_state    = ST_QUERY;
                    end else if (i_byte == ChSp) begin
                        res.closes = K_PATH;
                        n_state    = ST_VERSION_BEFORE;
                    end else begin
                        res.kind = K_PATH;
                    end
                end
                ST_QUERY: begin
                    if (i_byte == ChSp) begin
                        res.closes = K_QUERY;
                        n_state    = ST_VERSION_BEFORE;
                    end else begin
                        res.kind = K_QUERY;
                    end
                end
                ST_VERSION_BEFORE: begin
                    if (i_byte != ChUpH) begin
                        bad = 1'b1;
                    end else begin
                        res.kind = K_VERSION;
                        n_state  = ST_VERSION;
                    end
                end
                ST_VERSION: begin
                    if (i_byte == ChCr) begin
                        res.closes = K_VERSION;
                        n_state    = ST_VERSION_LF;
                    end else begin
                        res.kind = K_VERSION;
                    end
                end
                ST_VERSION_LF, ST_VALUE_LF: begin
                    if (i_byte != ChLf) begin
                        bad = 1'b1;
                    end else begin
                        n_state = ST_NAME;
                        n_match = '0;
                        n_miss  = 1'b0;
                    end
                end
                ST_NAME: begin
                    // A CR inside a name starts the blank line; the partial name is dropped.
                    if (i_byte == ChCr) begin
                        n_state = ST_BLANK_LF;
                    end else if (i_byte == ChColon) begin
                        res.closes = K_NAME;
                        n_state    = ST_VALUE_BEFORE;
                    end else if (is_ws(i_byte)) begin
                        bad = 1'b1;
                    end else begin
                        if (i_byte inside {[8'h41:8'h5A]}) begin
                            res.out_byte = i_byte + 8'd32;
                        end
                        res.kind = K_NAME;
                        if (r_match < MatchW'(CookieLen)
                                && cookie_char(r_match) == res.out_byte) begin
                            n_match = r_match + 1'b1;
                        end else begin
                            n_miss = 1'b1;
                        end
                    end
                end
                ST_VALUE_BEFORE, ST_VALUE: begin
                    if (i_byte == ChCr) begin
                        res.closes         = K_VALUE;
                        res.name_is_cookie = !r_miss && (r_match == MatchW'(CookieLen));
                        n_state            = ST_VALUE_LF;
                    end else if (r_state == ST_VALUE_BEFORE && is_ws(i_byte)) begin
                        // Leading whitespace before a value is dropped.
                        n_state = ST_VALUE_BEFORE;
                    end else begin
                        res.kind = K_VALUE;
                        n_state  = ST_VALUE;
                    end
                end
                ST_BLANK_LF: begin
                    if (i_byte != ChLf) begin
                        bad = 1'b1;
                    end else begin
                        res.headers_done = 1'b1;
                        n_state          = ST_DONE;
                    end
                end
                default: begin
                    // After the head, only extra LF bytes are tolerated.
                    if (i_byte != ChLf) begin
                        bad = 1'b1;
                    end
                end
            endcase
        end
        n_err           = r_err | bad;
        res.parse_error = n_err;
        o_result        = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_METHOD_BEFORE;
            r_match <= '0;
            r_miss  <= 1'b0;
            r_err   <= 1'b0;
        end else if (i_step) begin
            r_state <= n_state;
            r_match <= n_match;
            r_miss  <= n_miss;
            r_err   <= n_err;
        end
    end

endmodule

// File: rtl/http_request_header_tokenizer.sv
// HTTP request head tokenizer: one byte in, one tagged byte out per transaction.
// Path from input acceptance to result valid: input register, then result register.
// Throughput: one byte per cycle while results are taken; the parser state update is a single compare-and-select step.
// The result register holds while its result is not taken, and a held result also stalls a full input register;
// a new byte is still accepted meanwhile as long as the input register is empty.
// Reset (synchronous, active low) empties both stages and returns the parser to method start.
module http_request_header_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hrht_in_if.sink    i_in,
    hrht_out_if.source o_out
);
    import hrht_pkg::*;

    logic    r_s1_valid;
    t_byte   r_s1_byte;
    logic    r_out_valid;
    t_result r_out;
    logic    out_free;
    logic    s1_adv;
    t_result step_res;

    assign out_free = !r_out_valid || o_out.ready;
    assign s1_adv   = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || s1_adv;

    hrht_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_adv),
        .i_byte   (r_s1_byte),
        .o_result (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_byte <= i_in.in_byte;
        end
        if (s1_adv) begin
            r_out <= step_res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.out_byte       = r_out.out_byte;
    assign o_out.kind           = r_out.kind;
    assign o_out.closes         = r_out.closes;
    assign o_out.name_is_cookie = r_out.name_is_cookie;
    assign o_out.headers_done   = r_out.headers_done;
    assign o_out.parse_error    = r_out.parse_error;

endmodule

// File: tb/sv/tb_http_request_header_tokenizer.sv
// Self-checking testbench that streams a request head through the tokenizer and predicts results.
module tb_http_request_header_tokenizer;
    import hrht_pkg::*;

    localparam int HeaderBudget = 1350;
    localparam int TargetLen    = 1700;
    localparam int QuietTail    = 200;
    localparam int DrainAt      = 600;
    localparam int StallLimit   = 2000;
    localparam int SettleCycles = 8;

    localparam logic [8*CookieLen-1:0] CookieText  = "cookie";
    localparam string                  VersionTail = "TTP/1.1";

    typedef enum logic [3:0] {
        PS_METHOD_START, PS_METHOD, PS_PATH_START, PS_PATH, PS_QUERY,
        PS_VERSION_START, PS_VERSION, PS_VERSION_LF, PS_NAME, PS_VALUE_START,
        PS_VALUE, PS_VALUE_LF, PS_BLANK_LF, PS_DONE
    } t_pos;

    // Which malformed byte, if any, the request head carries.
    typedef enum int {
        FLT_SP_METHOD, FLT_SP_PATH, FLT_BAD_VERSION, FLT_VERSION_NO_LF,
        FLT_SPACE_IN_NAME, FLT_VALUE_NO_LF, FLT_BLANK_NO_LF, FLT_AFTER_DONE
    } t_fault;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hrht_in_if  in_ch ();
    hrht_out_if out_ch ();

    http_request_header_tokenizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    t_byte   request_bytes [$];
    t_result predicted_tokens [$];

    t_pos                pos;
    logic [MatchW-1:0]   cookie_seen;
    logic                cookie_broken;
    logic                frozen;

    int unsigned error_count = 0;
    int unsigned bytes_sent  = 0;
    int unsigned sender_gap;
    int unsigned receiver_stall;
    int unsigned idle_cycles;
    bit          drained = 1'b0;

    function automatic logic is_space(input t_byte b);
        return (b == ChSp) || (b >= ChHt && b <= ChCr);
    endfunction

    function automatic t_byte cookie_letter(input int idx);
        return CookieText[8*(CookieLen-1-idx) +: 8];
    endfunction

    function automatic void append_byte(input t_byte b);
        request_bytes = {request_bytes, b};
    endfunction

    function automatic t_result tokenize_byte(input t_byte b);
        t_result r;
        logic    bad;
        r.out_byte       = b;
        r.kind           = K_NONE;
        r.closes         = K_NONE;
        r.name_is_cookie = 1'b0;
        r.headers_done   = 1'b0;
        r.parse_error    = 1'b0;
        bad = 1'b0;
        if (!frozen) begin
            case (pos)
                PS_METHOD_START, PS_METHOD: begin
                    if (pos == PS_METHOD_START && b == ChSp) begin
                        bad = 1'b1;
                    end else if (pos == PS_METHOD && is_space(b)) begin
                        r.closes = K_METHOD;
                        pos = PS_PATH_START;
                    end else begin
                        if (b >= "a" && b <= "z") r.out_byte = b - 8'd32;
                        r.kind = K_METHOD;
                        pos = PS_METHOD;
                    end
                end
                PS_PATH_START: begin
                    if (b == ChSp) begin
                        bad = 1'b1;
                    end else begin
                        r.kind = K_PATH;
                        pos = PS_PATH;
                    end
                end
                PS_PATH: begin
                    if (b == ChQuest) begin
                        r.closes = K_PATH;
                        pos = PS_QUERY;
                    end else if (b == ChSp) begin
                        r.closes = K_PATH;
                        pos = PS_VERSION_START;
                    end else begin
                        r.kind = K_PATH;
                    end
                end
                PS_QUERY: begin
                    if (b == ChSp) begin
                        r.closes = K_QUERY;
                        pos = PS_VERSION_START;
                    end else begin
                        r.kind = K_QUERY;
                    end
                end
                PS_VERSION_START: begin
                    if (b != ChUpH) begin
                        bad = 1'b1;
                    end else begin
                        r.kind = K_VERSION;
                        pos = PS_VERSION;
                    end
                end
                PS_VERSION: begin
                    if (b == ChCr) begin
                        r.closes = K_VERSION;
                        pos = PS_VERSION_LF;
                    end else begin
                        r.kind = K_VERSION;
                    end
                end
                PS_VERSION_LF, PS_VALUE_LF: begin
                    if (b != ChLf) begin
                        bad = 1'b1;
                    end else begin
                        pos = PS_NAME;
                        cookie_seen = '0;
                        cookie_broken = 1'b0;
                    end
                end
                PS_NAME: begin
                    if (b == ChCr) begin
                        // A partial name is dropped and the line counts as the blank line.
                        pos = PS_BLANK_LF;
                    end else if (b == ChColon) begin
                        r.closes = K_NAME;
                        pos = PS_VALUE_START;
                    end else if (is_space(b)) begin
                        bad = 1'b1;
                    end else begin
                        if (b >= "A" && b <= "Z") r.out_byte = b + 8'd32;
                        r.kind = K_NAME;
                        if (cookie_seen < CookieLen
                                && cookie_letter(int'(cookie_seen)) == r.out_byte)
                            cookie_seen = cookie_seen + 1'b1;
                        else
                            cookie_broken = 1'b1;
                    end
                end
                PS_VALUE_START, PS_VALUE: begin
                    if (b == ChCr) begin
                        r.closes = K_VALUE;
                        r.name_is_cookie = !cookie_broken && cookie_seen == CookieLen;
                        pos = PS_VALUE_LF;
                    end else if (pos == PS_VALUE_START && is_space(b)) begin
                        // Leading whitespace of a value produces no token byte.
                    end else begin
                        r.kind = K_VALUE;
                        pos = PS_VALUE;
                    end
                end
                PS_BLANK_LF: begin
                    if (b != ChLf) begin
                        bad = 1'b1;
                    end else begin
                        r.headers_done = 1'b1;
                        pos = PS_DONE;
                    end
                end
                default: begin
                    if (b != ChLf) bad = 1'b1;
                end
            endcase
            if (bad) frozen = 1'b1;
        end
        r.parse_error = frozen;
        return r;
    endfunction

    // Half printable text, half any byte, never one of the excluded ones.
    function automatic t_byte rand_from(input bit ws_ok, input t_byte avoid_a, input t_byte avoid_b);
        t_byte b;
        do begin
            if ($urandom_range(0, 1)) b = t_byte'($urandom_range(8'h21, 8'h7E));
            else b = t_byte'($urandom_range(0, 255));
        end while ((!ws_ok && is_space(b)) || b == avoid_a || b == avoid_b);
        return b;
    endfunction

    function automatic t_byte space_byte(input bit cr_ok);
        t_byte b;
        do begin
            if ($urandom_range(0, 2) == 0) b = ChSp;
            else b = t_byte'($urandom_range(ChHt, ChCr));
        end while (!cr_ok && b == ChCr);
        return b;
    endfunction

    function automatic t_byte method_byte();
        case ($urandom_range(0, 3))
            0:       return t_byte'($urandom_range("A", "Z"));
            1:       return rand_from(1'b0, ChSp, ChSp);
            default: return t_byte'($urandom_range("a", "z"));
        endcase
    endfunction

    // Header names near "cookie" in random case, plus arbitrary names.
    task automatic push_name();
        int unsigned shape;
        int unsigned cut;
        t_byte       word [$];
        shape = $urandom_range(0, 5);
        for (int i = 0; i < CookieLen; i++) word = {word, cookie_letter(i)};
        case (shape)
            2: begin
                cut = $urandom_range(0, CookieLen - 1);
                while (word.size() > cut) void'(word.pop_back());
            end
            3: begin
                repeat ($urandom_range(1, 2)) begin
                    if ($urandom_range(0, 1)) word = {word, rand_from(1'b0, ChColon, ChColon)};
                    else word.push_front(rand_from(1'b0, ChColon, ChColon));
                end
            end
            4: word[$urandom_range(0, CookieLen - 1)] = t_byte'($urandom_range("0", "9"));
            5: begin
                word.delete();
                repeat ($urandom_range(0, 10)) word = {word, rand_from(1'b0, ChColon, ChColon)};
            end
            default: ;
        endcase
        foreach (word[i]) begin
            if (word[i] >= "a" && word[i] <= "z" && $urandom_range(0, 1)) word[i] = word[i] - 8'd32;
            append_byte(word[i]);
        end
    endtask

    task automatic push_value();
        repeat ($urandom_range(0, 3)) append_byte(space_byte(1'b0));
        if ($urandom_range(0, 3) != 0)
            repeat ($urandom_range(1, 24)) append_byte(rand_from(1'b1, ChCr, ChCr));
        append_byte(ChCr);
    endtask

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
        end
    endfunction

    // Byte source: holds each byte until taken, inserts idle bursts, pauses once to drain.
    always @(posedge i_clk) begin : drive
        logic  nxt_valid;
        t_byte nxt_byte;
        nxt_valid = in_ch.valid;
        nxt_byte  = in_ch.in_byte;
        if (!i_rst_n) begin
            pos = PS_METHOD_START;
            cookie_seen = '0;
            cookie_broken = 1'b0;
            frozen = 1'b0;
            sender_gap = 0;
            nxt_valid = 1'b0;
            nxt_byte  = '0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predicted_tokens = {predicted_tokens, tokenize_byte(in_ch.in_byte)};
                bytes_sent++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (bytes_sent == DrainAt && !drained) begin
                    if (predicted_tokens.size() == 0) drained = 1'b1;
                end else if (sender_gap > 0) begin
                    sender_gap--;
                end else if (request_bytes.size() != 0) begin
                    if (request_bytes.size() > QuietTail && $urandom_range(0, 9) == 0) begin
                        sender_gap = $urandom_range(0, 12);
                    end else begin
                        nxt_valid = 1'b1;
                        nxt_byte  = request_bytes.pop_front();
                    end
                end
            end
        end
        in_ch.valid   <= nxt_valid;
        in_ch.in_byte <= nxt_byte;
    end

    // Result sink: compares each transaction with the oldest prediction, stalls in bursts.
    always @(posedge i_clk) begin : observe
        t_result want;
        if (!i_rst_n) begin
            receiver_stall = 0;
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (predicted_tokens.size() == 0) begin
                    error_count++;
                    $display("%0t: result byte %0h arrived, expected nothing", $time,
                             out_ch.out_byte);
                end else begin
                    want = predicted_tokens.pop_front();
                    check_field("out_byte", want.out_byte, out_ch.out_byte);
                    check_field("kind", want.kind, out_ch.kind);
                    check_field("closes", want.closes, out_ch.closes);
                    check_field("name_is_cookie", want.name_is_cookie, out_ch.name_is_cookie);
                    check_field("headers_done", want.headers_done, out_ch.headers_done);
                    check_field("parse_error", want.parse_error, out_ch.parse_error);
                end
            end
            if (receiver_stall > 0) begin
                receiver_stall--;
                out_ch.ready <= 1'b0;
            end else if (request_bytes.size() > QuietTail && $urandom_range(0, 9) == 0) begin
                receiver_stall = $urandom_range(0, 12);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= StallLimit) begin
            $display("tb_http_request_header_tokenizer: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_fault      fault;
        int unsigned pick;
        i_rst_n <= 1'b0;

        // Only one fault kind is chosen per run, since the error is sticky and reset happens once.
        pick  = $urandom_range(0, 13);
        fault = (pick >= FLT_AFTER_DONE) ? FLT_AFTER_DONE : t_fault'(pick);

        // Request line.
        if (fault == FLT_SP_METHOD) append_byte(ChSp);
        if ($urandom_range(0, 5) == 0) append_byte(t_byte'($urandom_range(ChHt, ChCr)));
        else append_byte(method_byte());
        repeat ($urandom_range(0, 7)) append_byte(method_byte());
        append_byte(space_byte(1'b1));
        if (fault == FLT_SP_PATH) append_byte(ChSp);
        append_byte(rand_from(1'b1, ChSp, ChSp));
        repeat ($urandom_range(0, 20)) append_byte(rand_from(1'b1, ChSp, ChQuest));
        if ($urandom_range(0, 2) != 0) begin
            append_byte(ChQuest);
            repeat ($urandom_range(0, 15)) append_byte(rand_from(1'b1, ChSp, ChSp));
        end
        append_byte(ChSp);
        if (fault == FLT_BAD_VERSION) append_byte(rand_from(1'b1, ChUpH, ChUpH));
        append_byte(ChUpH);
        if ($urandom_range(0, 1)) begin
            for (int i = 0; i < VersionTail.len(); i++) append_byte(VersionTail[i]);
        end else begin
            repeat ($urandom_range(0, 8)) append_byte(rand_from(1'b1, ChCr, ChCr));
        end
        append_byte(ChCr);
        if (fault == FLT_VERSION_NO_LF) append_byte(rand_from(1'b1, ChLf, ChLf));
        else append_byte(ChLf);

        // Header lines.
        while (request_bytes.size() < HeaderBudget) begin
            push_name();
            append_byte(ChColon);
            push_value();
            append_byte(ChLf);
        end

        // End of the head, or the chosen malformed ending.
        case (fault)
            FLT_SPACE_IN_NAME: begin
                push_name();
                append_byte(space_byte(1'b0));
            end
            FLT_VALUE_NO_LF: begin
                push_name();
                append_byte(ChColon);
                push_value();
                append_byte(rand_from(1'b1, ChLf, ChLf));
            end
            default: begin
                if ($urandom_range(0, 1)) push_name();
                append_byte(ChCr);
                if (fault == FLT_BLANK_NO_LF) begin
                    append_byte(rand_from(1'b1, ChLf, ChLf));
                end else begin
                    append_byte(ChLf);
                    repeat ($urandom_range(0, 3)) append_byte(ChLf);
                    append_byte(rand_from(1'b1, ChLf, ChLf));
                end
            end
        endcase

        // Trailing bytes, all taken while the parser is frozen.
        while (request_bytes.size() < TargetLen) begin
            if ($urandom_range(0, 3) == 0) append_byte(ChLf);
            else append_byte(t_byte'($urandom_range(0, 255)));
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (request_bytes.size() != 0 || in_ch.valid || predicted_tokens.size() != 0);
        repeat (SettleCycles) @(posedge i_clk);

        if (error_count == 0)
            $display("tb_http_request_header_tokenizer: done, clean");
        else
            $display("tb_http_request_header_tokenizer: done, errors");
        $finish;
    end

endmodule

// File: http_request_header_tokenizer.f
rtl/hrht_pkg.sv
rtl/hrht_if.sv
rtl/hrht_parser.sv
rtl/http_request_header_tokenizer.sv
tb/sv/tb_http_request_header_tokenizer.sv
